// File: rtl/rgb2hsv_pkg.sv
// Shared widths, constants, sector codes and the pipeline word type for the
// RGB to HSV converter. No dependencies.
`default_nettype none

package rgb2hsv_pkg;

    // Channel and result widths
    localparam int CH_W  = 8;
    localparam int HUE_W = 15;

    // Hue divider: dividend 7680*e + delta (22 bits), divisor 2*delta (9 bits),
    // quotient below 2^13, so 13 restoring steps suffice.
    localparam int HDIV_W    = 22;
    localparam int HQ_W      = 13;
    localparam int HDEN_W    = 9;
    localparam int HUE_STEPS = HQ_W;

    // Saturation divider: dividend delta*255 (16 bits), divisor max (8 bits),
    // quotient at most 255.
    localparam int SDIV_W    = 16;
    localparam int SQ_W      = 8;
    localparam int SDEN_W    = 8;
    localparam int SAT_STEPS = SQ_W;

    // Hue angles in 1/64 degree
    localparam logic [HUE_W-1:0] HUE_SIXTY      = 15'd3840;
    localparam logic [HUE_W-1:0] HUE_FULL_TURN  = 15'd23040;
    localparam logic [HUE_W-1:0] HUE_RED_WRAP   = HUE_FULL_TURN - HUE_SIXTY;
    localparam logic [HUE_W-1:0] HUE_GREEN_OFS  = HUE_SIXTY;
    localparam logic [HUE_W-1:0] HUE_BLUE_OFS   = 15'd11520;

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    // One pipeline word. The num fields hold the dividend bits not yet
    // consumed; quotient bits shift in from the bottom.
    typedef struct packed {
        logic [HDEN_W-1:0] rem_h;
        logic [HQ_W-1:0]   num_h;
        logic [HDEN_W-1:0] den_h;
        logic [SDEN_W-1:0] rem_s;
        logic [SQ_W-1:0]   num_s;
        logic [SDEN_W-1:0] den_s;
        sector_t           sector;
        logic              undef;
        logic [CH_W-1:0]   bright;
    } pipe_word_t;

endpackage

`default_nettype wire

// File: rtl/rgb_to_hsv_converter.sv
// RGB to HSV converter, one pixel per clock while m_ready allows, fully pipelined.
// Depends on rgb2hsv_pkg for widths, hue constants and the pipeline word type.
//
//   Channel  | Ports                                            | Dir
//   ---------+--------------------------------------------------+-----
//   input    | s_valid, s_ready, s_red, s_green, s_blue         | in
//   result   | m_valid, m_ready, m_hue, m_saturation,           | out
//            | m_brightness, m_hue_undefined                    |
//
// A word is taken every cycle while the result side keeps up. The pipeline
// has one front stage (max, min, sector, dividends), 13 restoring divider
// stages and one output stage. The hue divider's 13 quotient bits set
// the depth; the saturation divider rides along in the first 8 of them.
// Reset (aresetn low, synchronous) clears only the valid bits.
// A stall on m_ready freezes the whole pipeline and drops s_ready; nothing
// is lost or repeated.
`default_nettype none

module rgb_to_hsv_converter (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [rgb2hsv_pkg::CH_W-1:0]   s_red,
    input  wire logic [rgb2hsv_pkg::CH_W-1:0]   s_green,
    input  wire logic [rgb2hsv_pkg::CH_W-1:0]   s_blue,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [rgb2hsv_pkg::HUE_W-1:0]       m_hue,
    output logic [rgb2hsv_pkg::CH_W-1:0]        m_saturation,
    output logic [rgb2hsv_pkg::CH_W-1:0]        m_brightness,
    output logic                                m_hue_undefined
);

    localparam int NSTG = rgb2hsv_pkg::HUE_STEPS;

    // Whole pipeline moves together when the output register is free or drained.
    logic advance;

    rgb2hsv_pkg::pipe_word_t stage_reg  [0:NSTG];
    rgb2hsv_pkg::pipe_word_t stage_next [0:NSTG];
    logic                    valid_reg  [0:NSTG];

    logic                               m_valid_reg;
    logic [rgb2hsv_pkg::HUE_W-1:0]      hue_reg, hue_next;
    logic [rgb2hsv_pkg::CH_W-1:0]       sat_reg;
    logic [rgb2hsv_pkg::CH_W-1:0]       bright_reg;
    logic                               undef_reg;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    // ------------------------------------------------------------------
    // Front stage: max, min, sector, and the two dividends.
    // Hue is rewritten as base - 60deg + round(7680*e / (2*delta)) with
    // e = diff + delta in 0..2*delta, so the divider sees no sign.
    // ------------------------------------------------------------------
    logic [rgb2hsv_pkg::CH_W-1:0]   mx, mn, delta, op_a, op_c;
    rgb2hsv_pkg::sector_t           sector;
    logic [rgb2hsv_pkg::CH_W+1:0]   e_wide;
    logic [rgb2hsv_pkg::HDEN_W-1:0] e_val;
    logic [rgb2hsv_pkg::HDIV_W-1:0] hdiv;
    logic [rgb2hsv_pkg::SDIV_W-1:0] sdiv;

    always_comb begin
        // Red wins ties over green, green over blue.
        if (s_red >= s_green && s_red >= s_blue) begin
            sector = rgb2hsv_pkg::SECTOR_RED;
            mx     = s_red;
        end else if (s_green >= s_blue) begin
            sector = rgb2hsv_pkg::SECTOR_GREEN;
            mx     = s_green;
        end else begin
            sector = rgb2hsv_pkg::SECTOR_BLUE;
            mx     = s_blue;
        end

        mn = s_red;
        if (s_green < mn) mn = s_green;
        if (s_blue < mn) mn = s_blue;
        delta = mx - mn;

        unique case (sector)
            rgb2hsv_pkg::SECTOR_RED: begin
                op_a = s_green;
                op_c = s_blue;
            end
            rgb2hsv_pkg::SECTOR_GREEN: begin
                op_a = s_blue;
                op_c = s_red;
            end
            rgb2hsv_pkg::SECTOR_BLUE: begin
                op_a = s_red;
                op_c = s_green;
            end
            default: begin
                op_a = s_red;
                op_c = s_green;
            end
        endcase

        e_wide = {2'd0, op_a} + {2'd0, delta} - {2'd0, op_c};
        e_val  = e_wide[rgb2hsv_pkg::HDEN_W-1:0];

        // 7680*e + delta, with 7680 = 8192 - 512
        hdiv = {e_val, 13'd0} - {4'd0, e_val, 9'd0} + {14'd0, delta};
        // delta*255 = delta*256 - delta
        sdiv = {delta, 8'd0} - {8'd0, delta};

        stage_next[0].rem_h  = hdiv[rgb2hsv_pkg::HDIV_W-1:rgb2hsv_pkg::HQ_W];
        stage_next[0].num_h  = hdiv[rgb2hsv_pkg::HQ_W-1:0];
        stage_next[0].den_h  = {delta, 1'b0};
        stage_next[0].rem_s  = sdiv[rgb2hsv_pkg::SDIV_W-1:rgb2hsv_pkg::SQ_W];
        stage_next[0].num_s  = sdiv[rgb2hsv_pkg::SQ_W-1:0];
        stage_next[0].den_s  = mx;
        stage_next[0].sector = sector;
        // Saturation is zero exactly when all channels are equal.
        stage_next[0].undef  = (delta == '0);
        stage_next[0].bright = mx;
    end

    // ------------------------------------------------------------------
    // Divider stages: one restoring step of the hue quotient per stage,
    // and one step of the saturation quotient in the first SAT_STEPS.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NSTG; k++) begin : g_step
        logic [rgb2hsv_pkg::HDEN_W:0] shift_h, sub_h;
        logic                         ge_h;

        always_comb begin
            shift_h = {stage_reg[k].rem_h, stage_reg[k].num_h[rgb2hsv_pkg::HQ_W-1]};
            sub_h   = shift_h - {1'b0, stage_reg[k].den_h};
            ge_h    = shift_h >= {1'b0, stage_reg[k].den_h};
        end

        if (k < rgb2hsv_pkg::SAT_STEPS) begin : g_sat
            logic [rgb2hsv_pkg::SDEN_W:0] shift_s, sub_s;
            logic                         ge_s;

            always_comb begin
                shift_s = {stage_reg[k].rem_s, stage_reg[k].num_s[rgb2hsv_pkg::SQ_W-1]};
                sub_s   = shift_s - {1'b0, stage_reg[k].den_s};
                ge_s    = shift_s >= {1'b0, stage_reg[k].den_s};

                stage_next[k+1]       = stage_reg[k];
                stage_next[k+1].rem_h = ge_h ? sub_h[rgb2hsv_pkg::HDEN_W-1:0]
                                             : shift_h[rgb2hsv_pkg::HDEN_W-1:0];
                stage_next[k+1].num_h = {stage_reg[k].num_h[rgb2hsv_pkg::HQ_W-2:0], ge_h};
                stage_next[k+1].rem_s = ge_s ? sub_s[rgb2hsv_pkg::SDEN_W-1:0]
                                             : shift_s[rgb2hsv_pkg::SDEN_W-1:0];
                stage_next[k+1].num_s = {stage_reg[k].num_s[rgb2hsv_pkg::SQ_W-2:0], ge_s};
            end
        end else begin : g_hue_only
            always_comb begin
                stage_next[k+1]       = stage_reg[k];
                stage_next[k+1].rem_h = ge_h ? sub_h[rgb2hsv_pkg::HDEN_W-1:0]
                                             : shift_h[rgb2hsv_pkg::HDEN_W-1:0];
                stage_next[k+1].num_h = {stage_reg[k].num_h[rgb2hsv_pkg::HQ_W-2:0], ge_h};
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: add the sector offset, wrap the red sector below zero,
    // and drop hue to zero for grey pixels.
    // ------------------------------------------------------------------
    logic [rgb2hsv_pkg::HUE_W-1:0] quo;

    always_comb begin
        quo = {2'd0, stage_reg[NSTG].num_h};
        unique case (stage_reg[NSTG].sector)
            rgb2hsv_pkg::SECTOR_RED: begin
                if (quo < rgb2hsv_pkg::HUE_SIXTY) begin
                    hue_next = quo + rgb2hsv_pkg::HUE_RED_WRAP;
                end else begin
                    hue_next = quo - rgb2hsv_pkg::HUE_SIXTY;
                end
            end
            rgb2hsv_pkg::SECTOR_GREEN: hue_next = quo + rgb2hsv_pkg::HUE_GREEN_OFS;
            rgb2hsv_pkg::SECTOR_BLUE:  hue_next = quo + rgb2hsv_pkg::HUE_BLUE_OFS;
            default:                   hue_next = '0;
        endcase
        if (stage_reg[NSTG].undef) begin
            hue_next = '0;
        end
    end

    // Valid bits: cleared by reset, advance with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= NSTG; i++) begin
                valid_reg[i] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg[0] <= s_valid;
            for (int i = 1; i <= NSTG; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
            m_valid_reg <= valid_reg[NSTG];
        end
    end

    // Payload: no reset, hold on stall.
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i <= NSTG; i++) begin
                stage_reg[i] <= stage_next[i];
            end
            hue_reg    <= hue_next;
            sat_reg    <= stage_reg[NSTG].undef ? '0 : stage_reg[NSTG].num_s;
            bright_reg <= stage_reg[NSTG].bright;
            undef_reg  <= stage_reg[NSTG].undef;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hue           = hue_reg;
    assign m_saturation    = sat_reg;
    assign m_brightness    = bright_reg;
    assign m_hue_undefined = undef_reg;

endmodule

`default_nettype wire
